// ----- hdl/aprs_ptb_pkg.sv -----
// Shared constants, types and digit-split functions for the APRS position text builder.
`timescale 1ns / 1ps

package aprs_ptb_pkg;

    localparam int TEXT_LEN = 20;
    localparam int CNT_W    = 5;

    // Coordinate limits in microdegrees; the bounds themselves are in range.
    localparam logic signed [27:0] LAT_LIMIT = 28'sd90000000;
    localparam logic signed [28:0] LON_LIMIT = 29'sd180000000;

    // Microdegrees per degree, and ceil(2^48 / 1e6): exact quotient for any 29-bit magnitude.
    localparam logic [19:0] UDEG_PER_DEG = 20'd1000000;
    localparam logic [28:0] DEG_RECIP    = 29'd281474977;
    localparam int          DEG_SHIFT    = 48;

    // ceil(2^33 / 1000): exact quotient for any value below 2^23.
    localparam logic [23:0] HUND_RECIP = 24'd8589935;
    localparam int          HUND_SHIFT = 33;
    localparam logic [12:0] MAX_HUND   = 13'd5999;

    // ASCII characters of the position text.
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    // Stage load enables handed to each coordinate datapath.
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } aprs_ptb_adv_t;

    // Result of one coordinate: whole degrees, hundredths of a minute, sign.
    typedef struct packed {
        logic [8:0]  deg;
        logic [12:0] hund;
        logic        neg;
    } aprs_ptb_coord_t;

    // Splits a degree count below 512 into hundreds, tens and ones digits.
    function automatic logic [11:0] dec3(input logic [8:0] val);
        logic [15:0] p_h;
        logic [3:0]  d_h;
        logic [6:0]  rem;
        logic [14:0] p_t;
        logic [3:0]  d_t;
        logic [3:0]  d_o;
        p_h = 16'(val) * 16'd41;
        d_h = p_h[15:12];
        rem = 7'(val - 9'(d_h) * 9'd100);
        p_t = 15'(rem) * 15'd205;
        d_t = p_t[14:11];
        d_o = 4'(rem - 7'(d_t) * 7'd10);
        return {d_h, d_t, d_o};
    endfunction

    // Splits hundredths of a minute (at most 5999) into four digits.
    function automatic logic [15:0] dec4(input logic [12:0] val);
        logic [26:0] p_th;
        logic [3:0]  d_th;
        logic [9:0]  r1;
        logic [15:0] p_h;
        logic [3:0]  d_h;
        logic [6:0]  r2;
        logic [14:0] p_t;
        logic [3:0]  d_t;
        logic [3:0]  d_o;
        p_th = 27'(val) * 27'd8389;
        d_th = p_th[26:23];
        r1   = 10'(val - 13'(d_th) * 13'd1000);
        p_h  = 16'(r1) * 16'd41;
        d_h  = p_h[15:12];
        r2   = 7'(r1 - 10'(d_h) * 10'd100);
        p_t  = 15'(r2) * 15'd205;
        d_t  = p_t[14:11];
        d_o  = 4'(r2 - 7'(d_t) * 7'd10);
        return {d_th, d_h, d_t, d_o};
    endfunction

    // ASCII character of one decimal digit.
    function automatic logic [7:0] ascii_digit(input logic [3:0] d);
        return CH_ZERO | {4'd0, d};
    endfunction

endpackage

// ----- hdl/aprs_ptb_coord.sv -----
// Three-stage datapath that turns one signed coordinate into degrees and hundredths of a minute.
`timescale 1ns / 1ps

module aprs_ptb_coord
    import aprs_ptb_pkg::*;
(
    input  logic                 clk,
    input  aprs_ptb_adv_t        adv,
    input  logic signed [28:0]   coord,
    output aprs_ptb_coord_t      result
);

    logic [28:0] mag;
    logic [57:0] deg_prod;
    logic [28:0] mag_reg;
    logic [8:0]  deg2_reg;
    logic        neg2_reg;

    logic [28:0] whole_udeg;
    logic [19:0] frac;
    logic [22:0] scaled_next;
    logic [22:0] scaled_reg;
    logic [8:0]  deg3_reg;
    logic        neg3_reg;

    logic [46:0] hund_prod;
    logic [12:0] hund_raw;
    logic [12:0] hund_next;
    logic [12:0] hund_reg;
    logic [8:0]  deg4_reg;
    logic        neg4_reg;

    // Stage 2: magnitude and whole degrees by reciprocal multiplication.
    assign mag      = coord[28] ? 29'(~coord + 29'sd1) : 29'(coord);
    assign deg_prod = 58'(mag) * 58'(DEG_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv.en2)
        begin
            mag_reg  <= mag;
            deg2_reg <= deg_prod[DEG_SHIFT+8:DEG_SHIFT];
            neg2_reg <= coord[28];
        end
    end

    // Stage 3: fractional degree, scaled for rounding to hundredths of a minute.
    assign whole_udeg  = 29'(deg2_reg) * 29'(UDEG_PER_DEG);
    assign frac        = 20'(mag_reg - whole_udeg);
    assign scaled_next = 23'(frac) * 23'd6 + 23'd500;

    always_ff @(posedge clk)
    begin
        if (adv.en3)
        begin
            scaled_reg <= scaled_next;
            deg3_reg   <= deg2_reg;
            neg3_reg   <= neg2_reg;
        end
    end

    // Stage 4: divide by 1000 and clamp so the minutes never read 60.
    assign hund_prod = 47'(scaled_reg) * 47'(HUND_RECIP);
    assign hund_raw  = hund_prod[HUND_SHIFT+12:HUND_SHIFT];
    assign hund_next = (hund_raw > MAX_HUND) ? MAX_HUND : hund_raw;

    always_ff @(posedge clk)
    begin
        if (adv.en4)
        begin
            hund_reg <= hund_next;
            deg4_reg <= deg3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    assign result.deg  = deg4_reg;
    assign result.hund = hund_reg;
    assign result.neg  = neg4_reg;

endmodule

// ----- hdl/aprs_position_text_builder_top.sv -----
// Top level of the APRS position text builder: input register, coordinate pipelines, byte serializer.
`timescale 1ns / 1ps
// An accepted request passes stages 2 to 4, then its first byte is loaded into the output buffer.
// A normal request gives 20 bytes in order; an out-of-range request gives a single flagged byte.
// The rate is set by the output serializer, which moves one byte per cycle while out_stall is low.
// Reset (rst_n, asynchronous, active low) empties every stage; no request is in flight after it.

module aprs_position_text_builder_top
    import aprs_ptb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [27:0] latitude_udeg,
    input  logic signed [28:0] longitude_udeg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         text_byte,
    output logic               final_byte,
    output logic               range_error
);

    // The pipeline has an input register (stage 1), three arithmetic stages inside each
    // coordinate unit (stages 2 to 4) and the output shift buffer. Each stage takes a new
    // request when it is empty or when its current request moves on in the same cycle, so
    // the pipeline fills up while the serializer is still sending the previous text.

    logic               v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic               v1_next, v2_next, v3_next, v4_next, vo_next;
    logic               en1, en2, en3, en4, load_out;
    logic               pop, last_byte;
    aprs_ptb_adv_t      adv;

    logic signed [27:0] lat_reg;
    logic signed [28:0] lon_reg;
    logic               err1;
    logic               err2_reg, err3_reg, err4_reg;

    aprs_ptb_coord_t    lat_res, lon_res;

    logic [7:0]         buf_reg [TEXT_LEN];
    logic [7:0]         text_next [TEXT_LEN];
    logic [CNT_W-1:0]   cnt_reg;
    logic               err_out_reg;

    logic [11:0]        lat_deg_dig, lon_deg_dig;
    logic [15:0]        lat_min_dig, lon_min_dig;

    // Output side: a byte leaves when the consumer does not stall. The buffer reloads only
    // once the last byte of the current text is leaving, or when it is empty.
    assign pop       = vo_reg && !out_stall;
    assign last_byte = err_out_reg || (cnt_reg == CNT_W'(TEXT_LEN - 1));
    assign load_out  = v4_reg && (!vo_reg || (pop && last_byte));

    // Stage enables ripple back from the output.
    assign en4      = v3_reg && (!v4_reg || load_out);
    assign en3      = v2_reg && (!v3_reg || en4);
    assign en2      = v1_reg && (!v2_reg || en3);
    assign in_stall = v1_reg && !en2;
    assign en1      = in_valid && !in_stall;

    assign adv.en2 = en2;
    assign adv.en3 = en3;
    assign adv.en4 = en4;

    always_comb
    begin
        v1_next = en1 ? 1'b1 : (en2 ? 1'b0 : v1_reg);
        v2_next = en2 ? 1'b1 : (en3 ? 1'b0 : v2_reg);
        v3_next = en3 ? 1'b1 : (en4 ? 1'b0 : v3_reg);
        v4_next = en4 ? 1'b1 : (load_out ? 1'b0 : v4_reg);
        vo_next = load_out ? 1'b1 : ((pop && last_byte) ? 1'b0 : vo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            vo_reg <= vo_next;
        end
    end

    // Stage 1: the accepted request.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lat_reg <= latitude_udeg;
            lon_reg <= longitude_udeg;
        end
    end

    // Range check on the signed values; the limits themselves are still valid positions.
    assign err1 = (lat_reg > LAT_LIMIT) || (lat_reg < -LAT_LIMIT) ||
                  (lon_reg > LON_LIMIT) || (lon_reg < -LON_LIMIT);

    // The error flag travels alongside the coordinate stages.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            err2_reg <= err1;
        end
        if (en3)
        begin
            err3_reg <= err2_reg;
        end
        if (en4)
        begin
            err4_reg <= err3_reg;
        end
    end

    aprs_ptb_coord u_lat
    (
        .clk    (clk),
        .adv    (adv),
        .coord  ({lat_reg[27], lat_reg}),
        .result (lat_res)
    );

    aprs_ptb_coord u_lon
    (
        .clk    (clk),
        .adv    (adv),
        .coord  (lon_reg),
        .result (lon_res)
    );

    // Text assembly for "!DDMM.mmH/DDDMM.mmH-". Latitude degrees stay below 100 whenever the
    // text is sent, so only the tens and ones digits are used there.
    assign lat_deg_dig = dec3(lat_res.deg);
    assign lon_deg_dig = dec3(lon_res.deg);
    assign lat_min_dig = dec4(lat_res.hund);
    assign lon_min_dig = dec4(lon_res.hund);

    always_comb
    begin
        text_next[0]  = CH_BANG;
        text_next[1]  = ascii_digit(lat_deg_dig[7:4]);
        text_next[2]  = ascii_digit(lat_deg_dig[3:0]);
        text_next[3]  = ascii_digit(lat_min_dig[15:12]);
        text_next[4]  = ascii_digit(lat_min_dig[11:8]);
        text_next[5]  = CH_DOT;
        text_next[6]  = ascii_digit(lat_min_dig[7:4]);
        text_next[7]  = ascii_digit(lat_min_dig[3:0]);
        text_next[8]  = lat_res.neg ? CH_S : CH_N;
        text_next[9]  = CH_SLASH;
        text_next[10] = ascii_digit(lon_deg_dig[11:8]);
        text_next[11] = ascii_digit(lon_deg_dig[7:4]);
        text_next[12] = ascii_digit(lon_deg_dig[3:0]);
        text_next[13] = ascii_digit(lon_min_dig[15:12]);
        text_next[14] = ascii_digit(lon_min_dig[11:8]);
        text_next[15] = CH_DOT;
        text_next[16] = ascii_digit(lon_min_dig[7:4]);
        text_next[17] = ascii_digit(lon_min_dig[3:0]);
        text_next[18] = lon_res.neg ? CH_W : CH_E;
        text_next[19] = CH_DASH;
        // An out-of-range request shows a zero byte.
        if (err4_reg)
        begin
            text_next[0] = 8'd0;
        end
    end

    // Output shift buffer: the byte on the port is always entry zero.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < TEXT_LEN; i++)
            begin
                buf_reg[i] <= text_next[i];
            end
            err_out_reg <= err4_reg;
        end
        else if (pop)
        begin
            for (int i = 0; i < TEXT_LEN - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[TEXT_LEN-1] <= 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load_out)
        begin
            cnt_reg <= '0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign out_valid   = vo_reg;
    assign text_byte   = buf_reg[0];
    assign final_byte  = last_byte;
    assign range_error = err_out_reg;

    // An error result is a single zero byte that closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> (final_byte && text_byte == 8'd0))
        else $error("error result is not a lone zero byte");

    // A text opens with the exclamation mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error && cnt_reg == '0) |-> (text_byte == CH_BANG))
        else $error("position text does not open with the data type mark");

    // Once a byte that is not the last one leaves, the next byte of the same text follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !final_byte) |=> (out_valid && !range_error))
        else $error("position text cut short");

    // The input side stalls only while the input register holds a request that cannot move.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg))
        else $error("input stalled with room in the pipeline");

endmodule
